// ----- hw/rtl/multicast_hash_filter_refcount_macros.svh -----
// Assertion macros shared by the multicast hash filter RTL.
`ifndef MULTICAST_HASH_FILTER_REFCOUNT_MACROS_SVH
`define MULTICAST_HASH_FILTER_REFCOUNT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MHF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mhf: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MHF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mhf: next-cycle check failed");

`endif

// ----- hw/rtl/mhf_pkg.sv -----
// Types and constants of the multicast hash filter.
`default_nettype none

package mhf_pkg;

    localparam int unsigned MAC_WIDTH   = 48;
    localparam int unsigned MAC_BYTES   = 6;
    localparam int unsigned CRC_WIDTH   = 32;
    localparam int unsigned NUM_BUCKETS = 64;
    localparam int unsigned BUCKET_W    = 6;
    localparam int unsigned WORD_BITS   = 32;

    localparam logic [CRC_WIDTH-1:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic OP_LEAVE = 1'b0;
    localparam logic OP_JOIN  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [1:0] STATUS_SATURATED = 2'd2;

    typedef struct packed {
        logic                 opcode;
        logic [MAC_WIDTH-1:0] group_mac;
    } req_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] hash_low_word;
        logic [WORD_BITS-1:0] hash_high_word;
        logic [BUCKET_W-1:0]  bucket;
        logic [1:0]           status;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_WRITE
    } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mhf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mhf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/mhf_crc.sv -----
// Bit-serial reflected CRC-32 over a MAC address, yielding the bucket index.
`default_nettype none

module mhf_crc (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [mhf_pkg::MAC_WIDTH-1:0]  group_mac,
    output logic                                done,
    output logic      [mhf_pkg::BUCKET_W-1:0]   bucket
);

    localparam int unsigned CNT_W = $clog2(mhf_pkg::MAC_WIDTH);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(mhf_pkg::MAC_WIDTH - 1);

    logic [mhf_pkg::MAC_WIDTH-1:0] shift_reg, shift_next;
    logic [mhf_pkg::CRC_WIDTH-1:0] crc_reg, crc_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [mhf_pkg::MAC_WIDTH-1:0] mac_swapped;
    logic                          feedback;

    // Put the first byte in the low bits so bit 0 is always the next one on the wire.
    always_comb
    begin
        for (int i = 0; i < mhf_pkg::MAC_BYTES; i++)
        begin
            mac_swapped[8*i +: 8] = group_mac[mhf_pkg::MAC_WIDTH - 8 - 8*i +: 8];
        end
    end

    assign feedback = crc_reg[0] ^ shift_reg[0];

    always_comb
    begin
        shift_next = shift_reg;
        crc_next   = crc_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            shift_next = mac_swapped;
            crc_next   = '1;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            shift_next = {1'b0, shift_reg[mhf_pkg::MAC_WIDTH-1:1]};
            crc_next   = {1'b0, crc_reg[mhf_pkg::CRC_WIDTH-1:1]}
                       ^ (feedback ? mhf_pkg::CRC_POLY : '0);
            cnt_next   = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST_BIT)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        crc_reg   <= crc_next;
    end

    // Final inversion and bit reversal: the top six reversed bits are crc bits 0..5.
    always_comb
    begin
        for (int i = 0; i < mhf_pkg::BUCKET_W; i++)
        begin
            bucket[mhf_pkg::BUCKET_W - 1 - i] = ~crc_reg[i];
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/multicast_hash_filter_refcount.sv -----
// Top level of the multicast hash filter with per-bucket reference counts.
//
// Each join or leave request goes through these steps from acceptance to
// result: the CRC-32 of the 48-bit address is computed one bit per clock, the
// bucket index is latched, the bucket count is read from the count RAM, and,
// once the result register is free, the updated count is written and the
// result register loaded. One request is in flight at a time; the next is
// accepted the cycle after the result is loaded, even while that result waits
// on rsp_stall. The serial CRC takes most of the time of a request. Counts and
// the hash table read as zero straight out of reset; no clearing pass is
// needed.
`default_nettype none

`include "multicast_hash_filter_refcount_macros.svh"

module multicast_hash_filter_refcount #(
    parameter int unsigned COUNT_WIDTH = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire mhf_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output mhf_pkg::rsp_t      rsp
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

    mhf_pkg::state_t state_reg, state_next;

    logic                                 opcode_reg, opcode_next;
    logic [mhf_pkg::BUCKET_W-1:0]         bucket_reg, bucket_next;
    logic [mhf_pkg::NUM_BUCKETS-1:0]      valid_reg, valid_next;
    logic [mhf_pkg::NUM_BUCKETS-1:0]      hash_reg, hash_next;
    logic                                 rsp_valid_reg, rsp_valid_next;
    mhf_pkg::rsp_t                        rsp_reg, rsp_next;

    logic                                 req_accept;
    logic                                 crc_done;
    logic [mhf_pkg::BUCKET_W-1:0]         crc_bucket;
    logic                                 ram_rd_en;
    logic                                 ram_wr_en;
    logic [COUNT_WIDTH-1:0]               ram_rd_data;
    logic [COUNT_WIDTH-1:0]               cur_count;
    logic [COUNT_WIDTH-1:0]               new_count;
    logic [1:0]                           new_status;
    logic [mhf_pkg::NUM_BUCKETS-1:0]      bucket_bit;
    logic                                 out_free;

    assign req_stall  = (state_reg != mhf_pkg::ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign out_free   = !rsp_valid_reg || !rsp_stall;

    mhf_crc u_crc (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (req_accept),
        .group_mac (req.group_mac),
        .done      (crc_done),
        .bucket    (crc_bucket)
    );

    mhf_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (mhf_pkg::NUM_BUCKETS)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (bucket_reg),
        .wr_data (new_count),
        .rd_en   (ram_rd_en),
        .rd_addr (bucket_reg),
        .rd_data (ram_rd_data)
    );

    // A bucket never written since reset holds count zero.
    assign cur_count  = valid_reg[bucket_reg] ? ram_rd_data : '0;
    assign bucket_bit = mhf_pkg::NUM_BUCKETS'(1) << bucket_reg;

    always_comb
    begin
        new_count  = cur_count;
        new_status = mhf_pkg::STATUS_OK;
        if (opcode_reg == mhf_pkg::OP_JOIN)
        begin
            if (cur_count == COUNT_MAX)
            begin
                new_status = mhf_pkg::STATUS_SATURATED;
            end
            else
            begin
                new_count = cur_count + COUNT_ONE;
            end
        end
        else
        begin
            if (cur_count == '0)
            begin
                new_status = mhf_pkg::STATUS_EMPTY;
            end
            else
            begin
                new_count = cur_count - COUNT_ONE;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        opcode_next    = opcode_reg;
        bucket_next    = bucket_reg;
        valid_next     = valid_reg;
        hash_next      = hash_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ram_rd_en      = 1'b0;
        ram_wr_en      = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            mhf_pkg::ST_IDLE:
            begin
                if (req_accept)
                begin
                    opcode_next = req.opcode;
                    state_next  = mhf_pkg::ST_HASH;
                end
            end
            mhf_pkg::ST_HASH:
            begin
                if (crc_done)
                begin
                    bucket_next = crc_bucket;
                    state_next  = mhf_pkg::ST_READ;
                end
            end
            mhf_pkg::ST_READ:
            begin
                ram_rd_en  = 1'b1;
                state_next = mhf_pkg::ST_WRITE;
            end
            mhf_pkg::ST_WRITE:
            begin
                // Hold the read count until the result register is free.
                if (out_free)
                begin
                    ram_wr_en  = 1'b1;
                    valid_next = valid_reg | bucket_bit;
                    if (opcode_reg == mhf_pkg::OP_JOIN)
                    begin
                        hash_next = hash_reg | bucket_bit;
                    end
                    else if (new_count == '0)
                    begin
                        hash_next = hash_reg & ~bucket_bit;
                    end
                    rsp_next.hash_low_word  = hash_next[mhf_pkg::WORD_BITS-1:0];
                    rsp_next.hash_high_word =
                        hash_next[mhf_pkg::NUM_BUCKETS-1:mhf_pkg::WORD_BITS];
                    rsp_next.bucket         = bucket_reg;
                    rsp_next.status         = new_status;
                    rsp_valid_next          = 1'b1;
                    state_next              = mhf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mhf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mhf_pkg::ST_IDLE;
            valid_reg     <= '0;
            hash_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            hash_reg      <= hash_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opcode_reg <= opcode_next;
        bucket_reg <= bucket_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `MHF_ASSERT_NOW(a_crc_done_in_hash, clk, rst_n,
        crc_done, state_reg == mhf_pkg::ST_HASH)
    `MHF_ASSERT_NEXT(a_empty_leave_keeps_table, clk, rst_n,
        state_reg == mhf_pkg::ST_WRITE && out_free &&
        new_status == mhf_pkg::STATUS_EMPTY, $stable(hash_reg))
    `MHF_ASSERT_NOW(a_saturated_bit_set, clk, rst_n,
        rsp_valid_reg && rsp_reg.status == mhf_pkg::STATUS_SATURATED,
        hash_reg[rsp_reg.bucket])
    `MHF_ASSERT_NEXT(a_write_loads_result, clk, rst_n,
        ram_wr_en, rsp_valid_reg && state_reg == mhf_pkg::ST_IDLE)

endmodule

`default_nettype wire
